[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the background band detector.
// Depends on nothing; the checks vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[hw/rtl/bbd_pkg.sv]
// Types and constants for the background band detector.
// Used by bbd_pixel_check and background_band_detector; depends on nothing.
`timescale 1ns / 1ps

package bbd_pkg;

   // Field widths fixed by the interface.
   localparam int CHAN_W   = 8;
   localparam int ROW_W    = 12;
   localparam int ABS_W    = 13;
   localparam int RUN_W    = 12;
   localparam int HEIGHT_W = 12;
   localparam int MARGIN_W = 12;
   localparam int WIDTH_W  = 13;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_BAND_HEIGHT     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COLOR_TOLERANCE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BG_RED          = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BG_GREEN        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BG_BLUE         = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_EDGE_MARGIN     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH     = 3'd6;

   // Register reset values.
   localparam logic [HEIGHT_W-1:0] RST_BAND_HEIGHT = 12'd16;
   localparam logic [CHAN_W-1:0]   RST_TOLERANCE   = 8'd16;
   localparam logic [CHAN_W-1:0]   RST_BG_CHANNEL  = 8'd255;
   localparam logic [MARGIN_W-1:0] RST_EDGE_MARGIN = 12'd0;
   localparam logic [WIDTH_W-1:0]  RST_IMAGE_WIDTH = 13'd1920;

   // The run counter sticks at its largest value.
   localparam logic [RUN_W-1:0] RUN_MAX = '1;

   typedef struct packed {
      logic [CHAN_W-1:0] tolerance;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } color_ref_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

endpackage

[hw/rtl/bbd_pixel_check.sv]
// Compares one pixel against the background color within the tolerance.
// Depends on bbd_pkg.
`timescale 1ns / 1ps

module bbd_pixel_check (
   input  bbd_pkg::color_ref_type color_ref,
   input  bbd_pkg::pixel_type     pixel,
   output logic                   close
);

   function automatic logic chan_close(
      input logic [bbd_pkg::CHAN_W-1:0] value,
      input logic [bbd_pkg::CHAN_W-1:0] ref_value,
      input logic [bbd_pkg::CHAN_W-1:0] tol
   );
      logic [bbd_pkg::CHAN_W-1:0] diff;
      diff = (value > ref_value) ? (value - ref_value) : (ref_value - value);
      return diff <= tol;
   endfunction

   assign close = chan_close(pixel.blue,  color_ref.blue,  color_ref.tolerance) &&
                  chan_close(pixel.green, color_ref.green, color_ref.tolerance) &&
                  chan_close(pixel.red,   color_ref.red,   color_ref.tolerance);

endmodule

[hw/rtl/background_band_detector.sv]
// A pixel beat accepted into the input register is judged when it leaves that register; the
// result of the last pixel is loaded into the result register and presented on rsp_*.
// Throughput: one pixel per cycle, set by the combinational row/run update between the input
// register and the result register; only a last pixel waits while an older result is stalled.
// Reset (synchronous, active high) loads the register defaults and clears the region state.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module background_band_detector #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                              clock,
   input  logic                              reset,

   // Pixel input channel.
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [bbd_pkg::CHAN_W-1:0]        req_blue,
   input  logic [bbd_pkg::CHAN_W-1:0]        req_green,
   input  logic [bbd_pkg::CHAN_W-1:0]        req_red,
   input  logic [bbd_pkg::ROW_W-1:0]         req_first_row,
   input  logic                              req_last_pixel,

   // Result channel, one beat per region.
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_found,
   output logic [bbd_pkg::ABS_W-1:0]         rsp_band_row,

   // Configuration write channel.
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bbd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bbd_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   // Column counter width follows the widest row; CW is wide enough to compare the
   // column, the margin and the clamped width without overflow.
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int CW    = ((COL_W + 1) > bbd_pkg::WIDTH_W) ? (COL_W + 1) : bbd_pkg::WIDTH_W;
   localparam logic [CW-1:0] MAX_WIDTH_C = CW'(MAX_WIDTH);
   localparam logic [CW-1:0] ONE_C       = CW'(1);

   // ---------------------------------------------------------------------------------------
   // Configuration registers. The port never pushes back; writes to unknown indexes drop.
   // ---------------------------------------------------------------------------------------
   logic [bbd_pkg::HEIGHT_W-1:0] band_height_ff, band_height_in;
   logic [bbd_pkg::CHAN_W-1:0]   tolerance_ff, tolerance_in;
   logic [bbd_pkg::CHAN_W-1:0]   bg_red_ff, bg_red_in;
   logic [bbd_pkg::CHAN_W-1:0]   bg_green_ff, bg_green_in;
   logic [bbd_pkg::CHAN_W-1:0]   bg_blue_ff, bg_blue_in;
   logic [bbd_pkg::MARGIN_W-1:0] edge_margin_ff, edge_margin_in;
   logic [bbd_pkg::WIDTH_W-1:0]  image_width_ff, image_width_in;

   assign csr_ready = 1'b1;

   always_comb begin
      band_height_in = band_height_ff;
      tolerance_in   = tolerance_ff;
      bg_red_in      = bg_red_ff;
      bg_green_in    = bg_green_ff;
      bg_blue_in     = bg_blue_ff;
      edge_margin_in = edge_margin_ff;
      image_width_in = image_width_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bbd_pkg::REG_BAND_HEIGHT:     band_height_in = csr_wdata[bbd_pkg::HEIGHT_W-1:0];
            bbd_pkg::REG_COLOR_TOLERANCE: tolerance_in   = csr_wdata[bbd_pkg::CHAN_W-1:0];
            bbd_pkg::REG_BG_RED:          bg_red_in      = csr_wdata[bbd_pkg::CHAN_W-1:0];
            bbd_pkg::REG_BG_GREEN:        bg_green_in    = csr_wdata[bbd_pkg::CHAN_W-1:0];
            bbd_pkg::REG_BG_BLUE:         bg_blue_in     = csr_wdata[bbd_pkg::CHAN_W-1:0];
            bbd_pkg::REG_EDGE_MARGIN:     edge_margin_in = csr_wdata[bbd_pkg::MARGIN_W-1:0];
            bbd_pkg::REG_IMAGE_WIDTH:     image_width_in = csr_wdata[bbd_pkg::WIDTH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         band_height_ff <= bbd_pkg::RST_BAND_HEIGHT;
         tolerance_ff   <= bbd_pkg::RST_TOLERANCE;
         bg_red_ff      <= bbd_pkg::RST_BG_CHANNEL;
         bg_green_ff    <= bbd_pkg::RST_BG_CHANNEL;
         bg_blue_ff     <= bbd_pkg::RST_BG_CHANNEL;
         edge_margin_ff <= bbd_pkg::RST_EDGE_MARGIN;
         image_width_ff <= bbd_pkg::RST_IMAGE_WIDTH;
      end else begin
         band_height_ff <= band_height_in;
         tolerance_ff   <= tolerance_in;
         bg_red_ff      <= bg_red_in;
         bg_green_ff    <= bg_green_in;
         bg_blue_ff     <= bg_blue_in;
         edge_margin_ff <= edge_margin_in;
         image_width_ff <= image_width_in;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Input register. A beat in this stage always moves on, except a last pixel whose result
   // would overwrite a result that the sink is still stalling.
   // ---------------------------------------------------------------------------------------
   logic                        s1_valid_ff, s1_valid_in;
   bbd_pkg::pixel_type          s1_pixel_ff;
   logic [bbd_pkg::ROW_W-1:0]   s1_first_ff;
   logic                        s1_last_ff;
   logic                        req_accept;
   logic                        s1_go;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_found_ff, rsp_found_in;
   logic [bbd_pkg::ABS_W-1:0]   rsp_band_row_ff, rsp_band_row_in;

   assign s1_go      = s1_valid_ff && !(s1_last_ff && rsp_valid_ff && rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_go;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pixel_ff <= '{red: req_red, green: req_green, blue: req_blue};
         s1_first_ff <= req_first_row;
         s1_last_ff  <= req_last_pixel;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Region state and the per-pixel update.
   // ---------------------------------------------------------------------------------------
   logic [COL_W-1:0]            col_ff, col_in;
   logic [bbd_pkg::ABS_W-1:0]   row_offset_ff, row_offset_in;
   logic                        row_bg_ff, row_bg_in;
   logic [bbd_pkg::RUN_W-1:0]   run_ff, run_in;
   logic                        found_ff, found_in;
   logic [bbd_pkg::ABS_W-1:0]   start_ff, start_in;
   logic [bbd_pkg::ROW_W-1:0]   base_ff, base_in;
   logic                        started_ff, started_in;

   bbd_pkg::color_ref_type      color_ref;
   logic                        pixel_close;

   assign color_ref = '{tolerance: tolerance_ff, red: bg_red_ff,
                        green: bg_green_ff, blue: bg_blue_ff};

   bbd_pixel_check u_pixel_check (
      .color_ref (color_ref),
      .pixel     (s1_pixel_ff),
      .close     (pixel_close)
   );

   logic [CW-1:0]                width_c;
   logic [CW-1:0]                col_x;
   logic [CW-1:0]                margin_x;
   logic [bbd_pkg::HEIGHT_W-1:0] need;
   logic [bbd_pkg::ROW_W-1:0]    base_use;
   logic                         in_window;
   logic                         row_bg_now;
   logic                         row_end;
   logic [bbd_pkg::RUN_W-1:0]    run_next;
   logic                         found_next;
   logic [bbd_pkg::ABS_W-1:0]    start_next;

   always_comb begin
      // A zero width behaves as one column, and rows never exceed the column counter.
      width_c = CW'(image_width_ff);
      if (width_c == '0) begin
         width_c = ONE_C;
      end else if (width_c > MAX_WIDTH_C) begin
         width_c = MAX_WIDTH_C;
      end
      need     = (band_height_ff == '0) ? bbd_pkg::HEIGHT_W'(1) : band_height_ff;
      col_x    = CW'(col_ff);
      margin_x = CW'(edge_margin_ff);
      base_use = started_ff ? base_ff : s1_first_ff;

      // When the margins cover the whole row no pixel is inside the window.
      in_window = (col_x >= margin_x) && (margin_x < width_c) && (col_x < (width_c - margin_x));
      row_bg_now = row_bg_ff && (!in_window || pixel_close);
      // A last pixel closes the row even when the row is short.
      row_end = ((col_x + ONE_C) >= width_c) || s1_last_ff;

      run_next   = run_ff;
      found_next = found_ff;
      start_next = start_ff;
      if (row_end) begin
         if (row_bg_now) begin
            if (run_ff < bbd_pkg::RUN_MAX) begin
               run_next = run_ff + 1'b1;
            end
            if (!found_ff && (run_next >= need)) begin
               found_next = 1'b1;
               // The band is the run_next rows that end with the row that just closed.
               start_next = bbd_pkg::ABS_W'(base_use) + row_offset_ff + 1'b1
                            - bbd_pkg::ABS_W'(run_next);
            end
         end else begin
            run_next = '0;
         end
      end

      col_in        = col_ff;
      row_offset_in = row_offset_ff;
      row_bg_in     = row_bg_ff;
      run_in        = run_ff;
      found_in      = found_ff;
      start_in      = start_ff;
      base_in       = base_ff;
      started_in    = started_ff;
      if (s1_go) begin
         if (s1_last_ff) begin
            // End of region: the result leaves and the state starts over.
            col_in        = '0;
            row_offset_in = '0;
            row_bg_in     = 1'b1;
            run_in        = '0;
            found_in      = 1'b0;
            start_in      = '0;
            base_in       = '0;
            started_in    = 1'b0;
         end else begin
            started_in = 1'b1;
            base_in    = base_use;
            run_in     = run_next;
            found_in   = found_next;
            start_in   = start_next;
            if (row_end) begin
               col_in        = '0;
               row_offset_in = row_offset_ff + 1'b1;
               row_bg_in     = 1'b1;
            end else begin
               col_in    = COL_W'(col_x + ONE_C);
               row_bg_in = row_bg_now;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_offset_ff <= '0;
         row_bg_ff     <= 1'b1;
         run_ff        <= '0;
         found_ff      <= 1'b0;
         start_ff      <= '0;
         base_ff       <= '0;
         started_ff    <= 1'b0;
      end else begin
         col_ff        <= col_in;
         row_offset_ff <= row_offset_in;
         row_bg_ff     <= row_bg_in;
         run_ff        <= run_in;
         found_ff      <= found_in;
         start_ff      <= start_in;
         base_ff       <= base_in;
         started_ff    <= started_in;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Result register. It loads on a last pixel and empties when the sink takes the beat.
   // ---------------------------------------------------------------------------------------
   always_comb begin
      rsp_found_in    = rsp_found_ff;
      rsp_band_row_in = rsp_band_row_ff;
      if (s1_go && s1_last_ff) begin
         rsp_valid_in    = 1'b1;
         rsp_found_in    = found_next;
         rsp_band_row_in = found_next ? start_next : '0;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff    <= rsp_found_in;
      rsp_band_row_ff <= rsp_band_row_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_band_row = rsp_band_row_ff;

   // ---------------------------------------------------------------------------------------
   // Checks.
   // ---------------------------------------------------------------------------------------
   // Input only stalls behind a held last pixel that has nowhere to put its result.
   `ASSERT_IMPLIES(a_stall_cause, clock, reset, req_stall,
                   s1_valid_ff && s1_last_ff && rsp_valid_ff && rsp_stall)
   // A region without a band reports row zero.
   `ASSERT_IMPLIES(a_row_zero, clock, reset, rsp_valid && !rsp_found, rsp_band_row == '0)
   // Closing a region leaves the state cleared for the next one.
   `ASSERT_NEXT(a_region_clear, clock, reset, s1_go && s1_last_ff,
                !started_ff && (col_ff == '0) && (row_offset_ff == '0) && !found_ff
                && rsp_valid)

endmodule

[bench/band_check_pkg.sv]
// Scoreboard for the background band detector bench: a pixel-by-pixel copy of the
// block's row and run tracking, plus the queue of region reports still expected.
// Depends on bbd_pkg for field widths, register indexes and reset values.
`timescale 1ns / 1ps

package band_check_pkg;
   import bbd_pkg::*;

   localparam int unsigned WIDTH_CAP = 4096;
   localparam int unsigned RUN_CAP   = 4095;

   typedef struct packed {
      logic             found;
      logic [ABS_W-1:0] band_row;
   } band_report_t;

   class band_scoreboard;
      logic [HEIGHT_W-1:0] band_height;
      logic [CHAN_W-1:0]   tolerance;
      logic [CHAN_W-1:0]   bg_red;
      logic [CHAN_W-1:0]   bg_green;
      logic [CHAN_W-1:0]   bg_blue;
      logic [MARGIN_W-1:0] edge_margin;
      logic [WIDTH_W-1:0]  image_width;

      logic [MARGIN_W-1:0] column_count;
      logic [ABS_W-1:0]    row_offset;
      bit                  row_clean;
      logic [RUN_W-1:0]    run_length;
      bit                  band_seen;
      logic [ABS_W-1:0]    band_start;
      logic [ROW_W-1:0]    base_row;
      bit                  region_open;

      band_report_t expected_bands[$];
      int unsigned  pixels_noted;
      int unsigned  reports_checked;
      int unsigned  bands_reported;
      int unsigned  errors;

      function new();
         band_height = RST_BAND_HEIGHT;
         tolerance   = RST_TOLERANCE;
         bg_red      = RST_BG_CHANNEL;
         bg_green    = RST_BG_CHANNEL;
         bg_blue     = RST_BG_CHANNEL;
         edge_margin = RST_EDGE_MARGIN;
         image_width = RST_IMAGE_WIDTH;
         pixels_noted    = 0;
         reports_checked = 0;
         bands_reported  = 0;
         errors          = 0;
         clear_region();
      endfunction

      function void clear_region();
         column_count = '0;
         row_offset   = '0;
         row_clean    = 1'b1;
         run_length   = '0;
         band_seen    = 1'b0;
         band_start   = '0;
         base_row     = '0;
         region_open  = 1'b0;
      endfunction

      function void write_register(input logic [CSR_IDX_W-1:0] index,
                                   input logic [CSR_DATA_W-1:0] data);
         case (index)
            REG_BAND_HEIGHT:     band_height = data[HEIGHT_W-1:0];
            REG_COLOR_TOLERANCE: tolerance   = data[CHAN_W-1:0];
            REG_BG_RED:          bg_red      = data[CHAN_W-1:0];
            REG_BG_GREEN:        bg_green    = data[CHAN_W-1:0];
            REG_BG_BLUE:         bg_blue     = data[CHAN_W-1:0];
            REG_EDGE_MARGIN:     edge_margin = data[MARGIN_W-1:0];
            REG_IMAGE_WIDTH:     image_width = data[WIDTH_W-1:0];
            default: ;
         endcase
      endfunction

      function bit channel_near(input logic [CHAN_W-1:0] level,
                                input logic [CHAN_W-1:0] target);
         int diff;
         diff = int'(level) - int'(target);
         if (diff < 0)
            diff = -diff;
         return diff <= int'(tolerance);
      endfunction

      function void note_pixel(input logic [CHAN_W-1:0] blue,
                               input logic [CHAN_W-1:0] green,
                               input logic [CHAN_W-1:0] red,
                               input logic [ROW_W-1:0]  first_row,
                               input logic              last_pixel);
         int unsigned  width;
         int unsigned  need;
         int unsigned  col;
         int unsigned  margin;
         int unsigned  start;
         bit           in_window;
         bit           pixel_ok;
         bit           row_bg;
         band_report_t report;

         width = image_width;
         if (width == 0)
            width = 1;
         if (width > WIDTH_CAP)
            width = WIDTH_CAP;
         need = (band_height == 0) ? 1 : band_height;
         pixels_noted++;

         if (!region_open) begin
            region_open = 1'b1;
            base_row    = first_row;
         end

         col    = column_count;
         margin = edge_margin;
         in_window = col >= margin && margin < width && col < width - margin;
         pixel_ok  = !in_window || (channel_near(blue, bg_blue) &&
                                    channel_near(green, bg_green) &&
                                    channel_near(red, bg_red));
         row_bg = row_clean && pixel_ok;

         if (col + 1 >= width || last_pixel) begin
            if (row_bg) begin
               if (run_length < RUN_CAP)
                  run_length = run_length + 1'b1;
               if (!band_seen && run_length >= need) begin
                  band_seen  = 1'b1;
                  start      = int'(base_row) + int'(row_offset) + 1 - int'(run_length);
                  band_start = start[ABS_W-1:0];
               end
            end else begin
               run_length = '0;
            end
            column_count = '0;
            row_offset   = row_offset + 1'b1;
            row_clean    = 1'b1;
         end else begin
            column_count = column_count + 1'b1;
            row_clean    = row_bg;
         end

         if (last_pixel) begin
            report.found    = band_seen;
            report.band_row = band_seen ? band_start : '0;
            expected_bands.push_back(report);
            clear_region();
         end
      endfunction

      function void check_report(input logic found, input logic [ABS_W-1:0] band_row);
         band_report_t want;
         if (expected_bands.size() == 0) begin
            $display("%0t: report with none expected: expected nothing, actual found=%0d row=%0d",
                     $time, found, band_row);
            errors++;
            return;
         end
         want = expected_bands.pop_front();
         reports_checked++;
         if (want.found)
            bands_reported++;
         if (found !== want.found) begin
            $display("%0t: found mismatch: expected %0d, actual %0d", $time, want.found, found);
            errors++;
         end
         if (band_row !== want.band_row) begin
            $display("%0t: band_row mismatch: expected %0d, actual %0d",
                     $time, want.band_row, band_row);
            errors++;
         end
      endfunction
   endclass

endpackage

[bench/tb.sv]
// Top-level bench for background_band_detector: directed regions, one longer region
// and about a thousand random pixel beats under changing flow control, checked by the scoreboard.
// Depends on bbd_pkg, band_check_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb;
   import bbd_pkg::*;
   import band_check_pkg::*;

   // Size of the random part, in pixel beats.
   localparam int RANDOM_PIXELS = 1050;
   // Cycles allowed after the last report before touching the registers or ending.
   // The result of the last pixel passes the input and result registers before it appears.
   localparam int SETTLE_CYCLES = 6;

   // How a random row is built: all window pixels near the background color, one
   // window pixel pushed out of tolerance, or plain noise everywhere.
   typedef enum int {ROW_CLEAN, ROW_ONE_BAD, ROW_NOISE} row_kind_t;

   // Flow control thirds of the random part: slow receiver, slow sender, no gaps.
   typedef enum int {IDLE_SLOW_SINK, IDLE_SLOW_SOURCE, IDLE_NONE} idle_mode_t;

   typedef struct packed {
      logic [HEIGHT_W-1:0] height;
      logic [CHAN_W-1:0]   tol;
      logic [CHAN_W-1:0]   red;
      logic [CHAN_W-1:0]   green;
      logic [CHAN_W-1:0]   blue;
      logic [MARGIN_W-1:0] margin;
      logic [WIDTH_W-1:0]  width;
   } band_setting_t;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [CHAN_W-1:0]     req_blue;
   logic [CHAN_W-1:0]     req_green;
   logic [CHAN_W-1:0]     req_red;
   logic [ROW_W-1:0]      req_first_row;
   logic                  req_last_pixel;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_found;
   logic [ABS_W-1:0]      rsp_band_row;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Percent chances that the sender holds back a beat and that the receiver stalls.
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;

   band_scoreboard board = new();
   band_setting_t  setting;

   background_band_detector dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_blue       (req_blue),
      .req_green      (req_green),
      .req_red        (req_red),
      .req_first_row  (req_first_row),
      .req_last_pixel (req_last_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_found      (rsp_found),
      .rsp_band_row   (rsp_band_row),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The receiver stalls at random. The new value is applied with a nonblocking
   // assignment, so the block sees a stable stall level around each edge.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // Result monitor. Right after the edge every signal still holds the value the
   // block saw at that edge, so a beat is taken exactly when valid was high and
   // stall was low.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_report(rsp_found, rsp_band_row);
   end

   // Width as the block applies it: zero reads as one and anything above the
   // largest supported width is clamped.
   function automatic int shown_width(input band_setting_t s);
      int w;
      w = s.width;
      if (w == 0)
         w = 1;
      if (w > int'(WIDTH_CAP))
         w = WIDTH_CAP;
      return w;
   endfunction

   // A channel level within tolerance of the target; often right on a boundary.
   function automatic logic [CHAN_W-1:0] level_near(input int target, input int tol);
      int lo;
      int hi;
      lo = (target > tol) ? target - tol : 0;
      hi = (target + tol < 255) ? target + tol : 255;
      case ($urandom_range(0, 3))
         0:       return lo[CHAN_W-1:0];
         1:       return hi[CHAN_W-1:0];
         default: return $urandom_range(hi, lo);
      endcase
   endfunction

   // A channel level just outside tolerance, when the tolerance leaves any room.
   function automatic logic [CHAN_W-1:0] level_far(input int target, input int tol);
      int below;
      int above;
      below = target - tol - 1;
      above = target + tol + 1;
      if (below >= 0 && (above > 255 || $urandom_range(0, 1) == 0))
         return $urandom_range(below, 0);
      if (above <= 255)
         return $urandom_range(255, above);
      return $urandom_range(255, 0);
   endfunction

   // Send one pixel beat and note it in the scoreboard once it is taken. The
   // valid line is only lowered when a gap is inserted, so back-to-back beats
   // never see a low and a high assignment in the same step.
   task automatic send_pixel(input logic [CHAN_W-1:0] blue, input logic [CHAN_W-1:0] green,
                             input logic [CHAN_W-1:0] red, input logic [ROW_W-1:0] first_row,
                             input logic last_pixel);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_blue       <= blue;
      req_green      <= green;
      req_red        <= red;
      req_first_row  <= first_row;
      req_last_pixel <= last_pixel;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      board.note_pixel(blue, green, red, first_row, last_pixel);
   endtask

   // Stop sending and wait until every report of the finished regions is back,
   // then let the block settle before anything else happens.
   task automatic drain();
      req_valid <= 1'b0;
      while (board.expected_bands.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all seven registers in index order, then drop the write strobe.
   task automatic apply_setting(input band_setting_t s);
      logic [CSR_DATA_W-1:0] values [int'(REG_IMAGE_WIDTH) + 1];
      values[REG_BAND_HEIGHT]     = s.height;
      values[REG_COLOR_TOLERANCE] = s.tol;
      values[REG_BG_RED]          = s.red;
      values[REG_BG_GREEN]        = s.green;
      values[REG_BG_BLUE]         = s.blue;
      values[REG_EDGE_MARGIN]     = s.margin;
      values[REG_IMAGE_WIDTH]     = s.width;
      for (int i = 0; i <= int'(REG_IMAGE_WIDTH); i++) begin
         csr_valid <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= values[i];
         @(posedge clock);
         while (!csr_ready)
            @(posedge clock);
         board.write_register(CSR_IDX_W'(i), values[i]);
      end
      csr_valid <= 1'b0;
      setting = s;
   endtask

   // Mostly small heights and widths so that bands actually form within a few
   // rows; now and then zero, oversized or fully random values.
   function automatic band_setting_t random_setting();
      band_setting_t s;
      int            pick;
      pick = $urandom_range(0, 9);
      if (pick < 8)
         s.height = $urandom_range(4, 1);
      else if (pick == 8)
         s.height = '0;
      else
         s.height = $urandom_range(4095, 0);
      s.tol   = ($urandom_range(0, 1) == 0) ? $urandom_range(40, 0) : $urandom_range(255, 0);
      s.red   = $urandom_range(255, 0);
      s.green = $urandom_range(255, 0);
      s.blue  = $urandom_range(255, 0);
      pick = $urandom_range(0, 9);
      if (pick < 7)
         s.width = $urandom_range(8, 1);
      else if (pick == 7)
         s.width = '0;
      else if (pick == 8)
         s.width = $urandom_range(16, 9);
      else
         s.width = $urandom_range(8191, 4097);
      s.margin = ($urandom_range(0, 9) < 7) ? $urandom_range(2, 0) : $urandom_range(4095, 0);
      return s;
   endfunction

   function automatic void pick_idle(input idle_mode_t mode);
      if (mode == IDLE_SLOW_SINK) begin
         send_idle_pct = 24;
         stall_pct     = 76;
      end else if (mode == IDLE_SLOW_SOURCE) begin
         send_idle_pct = 76;
         stall_pct     = 24;
      end else begin
         send_idle_pct = 0;
         stall_pct     = 0;
      end
   endfunction

   // Send one region of the given number of rows. A nonzero last_len cuts the
   // final row short, which the block must still count as a row. The row number
   // is random on every beat; only the first beat of the region should matter.
   task automatic send_region(input int rows, input int last_len);
      int                w;
      int                lo;
      int                hi;
      int                len;
      int                bad_col;
      row_kind_t         kind;
      logic [CHAN_W-1:0] b;
      logic [CHAN_W-1:0] g;
      logic [CHAN_W-1:0] r;
      w  = shown_width(setting);
      lo = setting.margin;
      hi = (lo < w) ? w - lo : 0;
      for (int row = 0; row < rows; row++) begin
         len = (row == rows - 1 && last_len > 0) ? last_len : w;
         case ($urandom_range(0, 19))
            0, 1:       kind = ROW_NOISE;
            2, 3, 4:    kind = ROW_ONE_BAD;
            default:    kind = ROW_CLEAN;
         endcase
         bad_col = $urandom_range(w - 1, 0);
         for (int col = 0; col < len; col++) begin
            b = $urandom_range(255, 0);
            g = $urandom_range(255, 0);
            r = $urandom_range(255, 0);
            if (kind != ROW_NOISE && col >= lo && col < hi) begin
               b = level_near(setting.blue, setting.tol);
               g = level_near(setting.green, setting.tol);
               r = level_near(setting.red, setting.tol);
               if (kind == ROW_ONE_BAD && col == bad_col) begin
                  case ($urandom_range(0, 2))
                     0:       b = level_far(setting.blue, setting.tol);
                     1:       g = level_far(setting.green, setting.tol);
                     default: r = level_far(setting.red, setting.tol);
                  endcase
               end
            end
            send_pixel(b, g, r, $urandom_range(4095, 0), row == rows - 1 && col == len - 1);
         end
      end
   endtask

   // Region shape follows the current setting: enough rows to reach the band
   // height for small heights, and a single short partial row when the width
   // is so large that a full row would dominate the run.
   task automatic send_random_region();
      int w;
      int need;
      int rows;
      int last_len;
      w    = shown_width(setting);
      need = (setting.height == 0) ? 1 : setting.height;
      if (w > 16) begin
         send_region(1, $urandom_range(20, 1));
      end else begin
         rows     = (need <= 6) ? $urandom_range(need + 3, 1) : $urandom_range(6, 1);
         last_len = ($urandom_range(0, 3) == 0) ? $urandom_range(w, 1) : 0;
         send_region(rows, last_len);
      end
   endtask

   initial begin
      int         random_start;
      idle_mode_t mode;
      int         third;

      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_blue       <= '0;
      req_green      <= '0;
      req_red        <= '0;
      req_first_row  <= '0;
      req_last_pixel <= 1'b0;
      csr_valid      <= 1'b0;
      csr_index      <= '0;
      csr_wdata      <= '0;
      setting = '{height: RST_BAND_HEIGHT, tol: RST_TOLERANCE, red: RST_BG_CHANNEL,
                  green: RST_BG_CHANNEL, blue: RST_BG_CHANNEL, margin: RST_EDGE_MARGIN,
                  width: RST_IMAGE_WIDTH};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values: a short partial row of near-white pixels, the last one
      // right at the tolerance edge. One row never makes a band of sixteen.
      send_pixel(8'd255, 8'd255, 8'd255, 12'd4095, 1'b0);
      send_pixel(8'd239, 8'd239, 8'd239, 12'd17, 1'b0);
      send_pixel(8'd240, 8'd255, 8'd239, 12'd3, 1'b1);
      drain();

      // Zero band height acts as one, zero tolerance on a black background.
      // The band starts on the second row, one past row 4095.
      apply_setting('{height: 12'd0, tol: 8'd0, red: 8'd0, green: 8'd0, blue: 8'd0,
                      margin: 12'd0, width: 13'd2});
      send_pixel(8'd0, 8'd0, 8'd0, 12'd4095, 1'b0);
      send_pixel(8'd1, 8'd0, 8'd0, 12'd0, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd0, 12'd1, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd0, 12'd2, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd255, 12'd3, 1'b1);
      // A region of one pixel: a partial row that is background on its own.
      send_pixel(8'd0, 8'd0, 8'd0, 12'd0, 1'b1);
      drain();

      // Largest height and tolerance, oversized width and a margin that leaves
      // no window at all: every row is background, but one row is no band.
      apply_setting('{height: 12'd4095, tol: 8'd255, red: 8'd255, green: 8'd0, blue: 8'd128,
                      margin: 12'd4095, width: 13'd8191});
      send_pixel(8'd0, 8'd255, 8'd0, 12'd2048, 1'b0);
      send_pixel(8'd255, 8'd0, 8'd255, 12'd2049, 1'b0);
      send_pixel(8'd17, 8'd200, 8'd3, 12'd0, 1'b0);
      send_pixel(8'd128, 8'd0, 8'd255, 12'd4095, 1'b1);
      drain();

      // Margin of one on a four pixel row: edge pixels are garbage, inner pixels
      // sit on the background color, at the tolerance or one past it. The first row fails by one
      // step of blue, so the band of two starts at row 1001.
      apply_setting('{height: 12'd2, tol: 8'd10, red: 8'd100, green: 8'd150, blue: 8'd200,
                      margin: 12'd1, width: 13'd4});
      send_pixel(8'd0, 8'd0, 8'd0, 12'd1000, 1'b0);
      send_pixel(8'd211, 8'd150, 8'd100, 12'd0, 1'b0);
      send_pixel(8'd200, 8'd150, 8'd100, 12'd0, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd255, 12'd0, 1'b0);
      send_pixel(8'd0, 8'd255, 8'd0, 12'd0, 1'b0);
      send_pixel(8'd210, 8'd140, 8'd110, 12'd0, 1'b0);
      send_pixel(8'd190, 8'd160, 8'd90, 12'd0, 1'b0);
      send_pixel(8'd255, 8'd0, 8'd255, 12'd0, 1'b0);
      send_pixel(8'd9, 8'd9, 8'd9, 12'd0, 1'b0);
      send_pixel(8'd200, 8'd150, 8'd100, 12'd0, 1'b0);
      send_pixel(8'd200, 8'd150, 8'd100, 12'd0, 1'b0);
      send_pixel(8'd77, 8'd1, 8'd254, 12'd0, 1'b1);
      drain();

      // A longer region of single-pixel rows. A broken row cuts the first run
      // short of the height and restarts it; the band then starts past row 4095,
      // so its absolute row needs the thirteenth bit.
      apply_setting('{height: 12'd40, tol: 8'd0, red: 8'd7, green: 8'd7, blue: 8'd7,
                      margin: 12'd0, width: 13'd1});
      for (int row = 0; row < 120; row++)
         send_pixel(8'd7, 8'd7, (row == 30) ? 8'd8 : 8'd7,
                    (row == 0) ? 12'd4095 : 12'($urandom_range(4095, 0)), row == 119);
      drain();

      // Random part: a fresh setting every few regions, flow control by thirds.
      random_start = board.pixels_noted;
      while (board.pixels_noted < random_start + RANDOM_PIXELS) begin
         third = (board.pixels_noted - random_start) * 3 / RANDOM_PIXELS;
         mode  = (third == 0) ? IDLE_SLOW_SINK : (third == 1) ? IDLE_SLOW_SOURCE : IDLE_NONE;
         drain();
         apply_setting(random_setting());
         repeat ($urandom_range(4, 2)) begin
            pick_idle(mode);
            send_random_region();
         end
      end
      drain();
      stall_pct = 0;
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("tb: %0d pixel beats sent, %0d region reports checked, %0d of them with a band",
               board.pixels_noted, board.reports_checked, board.bands_reported);
      $display("tb: covered zero and largest band heights, empty windows, clamped widths,");
      $display("tb: partial last rows, run restarts and band rows past 4095 under flow control");
      if (board.errors == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

   // Watchdog. A correct run takes well under a tenth of this time even with
   // the heaviest idling, so reaching it means the block hung.
   initial begin
      #5_000_000;
      $display("tb: done, errors");
      $finish;
   end

endmodule
